>>> design/hilbert_coords_to_index_macros.svh
// assertion macros for the hilbert index encoder
// used by the top level; needs nothing else
`ifndef HILBERT_COORDS_TO_INDEX_MACROS_SVH
`define HILBERT_COORDS_TO_INDEX_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HCI_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define HCI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/hci_pkg.sv
// shared constants, types and register codes for the hilbert index encoder
// no dependencies
package hci_pkg;

	localparam int MAX_DIMS   = 8;
	localparam int MAX_BITS   = 32;
	localparam int NUM_FIELDS = 8;
	localparam int COORD_W    = 32;
	localparam int IDX_W      = 63;
	localparam int IDX_IW     = $clog2(IDX_W);
	localparam int DIMS_W     = 4;
	localparam int BITS_W     = 6;
	localparam int PROD_W     = DIMS_W + BITS_W;
	localparam int LVL_W      = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
	localparam int NUM_LEVELS = MAX_BITS - 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	typedef logic [DIMS_W-1:0]   dims_t;
	typedef logic [BITS_W-1:0]   bits_t;
	typedef logic [PROD_W-1:0]   prod_t;
	typedef logic [MAX_BITS-1:0] word_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// register indexes
	localparam cfg_idx_t REG_DIMS = cfg_idx_t'(0);
	localparam cfg_idx_t REG_BITS = cfg_idx_t'(1);

	localparam dims_t DIMS_RESET = dims_t'(2);
	localparam bits_t BITS_RESET = bits_t'(16);

	typedef struct packed {
		dims_t dims;
		bits_t bits;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] coord_7;
		logic [COORD_W-1:0] coord_6;
		logic [COORD_W-1:0] coord_5;
		logic [COORD_W-1:0] coord_4;
		logic [COORD_W-1:0] coord_3;
		logic [COORD_W-1:0] coord_2;
		logic [COORD_W-1:0] coord_1;
		logic [COORD_W-1:0] coord_0;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] hilbert_index;
		logic             config_error;
	} out_item_t;

	typedef word_t [MAX_DIMS-1:0] axes_t;

	typedef struct packed {
		logic  valid;
		axes_t x;
	} stage_t;

endpackage

>>> design/hilbert_coords_to_index.sv
// Hilbert curve encoder, top level: configuration registers and pipeline
// depends on hci_pkg, hci_level, hci_gray, hci_pack and the macro header
//
// Turns one point of up to eight coordinates into its Hilbert curve index
// (transpose method). A point can be taken in every cycle; each one passes
// through one register stage for each of the 31 bit levels of the undo
// pass, one for the Gray encode and one for the interleave and
// output register. Stages that hold no point let the points behind them move
// up while the output is stalled, so input stalls only once the pipeline is
// full. Write dims (index 0) and bits (index 1) only while no point is in
// flight; config_error is set and the index is zero when dims times bits
// exceeds 63 or either register is out of range.
`include "hilbert_coords_to_index_macros.svh"

module hilbert_coords_to_index (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  hci_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output hci_pkg::out_item_t               out_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hci_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hci_pkg::CFG_DATA_W-1:0]   cfg_data
);

	hci_pkg::dims_t  dims_q;
	hci_pkg::bits_t  bits_q;
	hci_pkg::cfg_t   cfg;
	hci_pkg::prod_t  idx_span;

	logic [hci_pkg::NUM_FIELDS-1:0][hci_pkg::COORD_W-1:0] fields;
	hci_pkg::word_t  coord_mask;
	hci_pkg::axes_t  in_x;

	hci_pkg::stage_t st [hci_pkg::NUM_LEVELS+1];
	logic            rdy [hci_pkg::NUM_LEVELS+1];
	hci_pkg::stage_t gray_st;
	logic            gray_rdy;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= hci_pkg::DIMS_RESET;
			bits_q <= hci_pkg::BITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hci_pkg::REG_DIMS: begin
					dims_q <= cfg_data[hci_pkg::DIMS_W-1:0];
				end
				hci_pkg::REG_BITS: begin
					bits_q <= cfg_data[hci_pkg::BITS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.dims = dims_q;
	assign cfg.bits = bits_q;
	assign idx_span = hci_pkg::prod_t'(dims_q) * hci_pkg::prod_t'(bits_q);

	// mask coordinates to bits bits; axes without a field read as zero
	assign fields = {in_item.coord_7, in_item.coord_6, in_item.coord_5, in_item.coord_4,
		in_item.coord_3, in_item.coord_2, in_item.coord_1, in_item.coord_0};

	always_comb begin
		for (int j = 0; j < hci_pkg::MAX_BITS; j++) begin
			coord_mask[j] = hci_pkg::bits_t'(j) < bits_q;
		end
		for (int i = 0; i < hci_pkg::MAX_DIMS; i++) begin
			if (i < hci_pkg::NUM_FIELDS) begin
				in_x[i] = fields[i][hci_pkg::MAX_BITS-1:0] & coord_mask;
			end else begin
				in_x[i] = '0;
			end
		end
	end

	assign st[0] = {in_valid, in_x};

	assign in_stall = !rdy[0];

	// undo pass, top bit level first
	for (genvar k = 0; k < hci_pkg::NUM_LEVELS; k++) begin : g_level
		hci_level u_level (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg),
			.level    (hci_pkg::LVL_W'(hci_pkg::NUM_LEVELS - k)),
			.up       (st[k]),
			.up_ready (rdy[k]),
			.dn       (st[k+1]),
			.dn_ready (rdy[k+1])
		);
	end

	hci_gray u_gray (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up       (st[hci_pkg::NUM_LEVELS]),
		.up_ready (rdy[hci_pkg::NUM_LEVELS]),
		.dn       (gray_st),
		.dn_ready (gray_rdy)
	);

	hci_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.up        (gray_st),
		.up_ready  (gray_rdy),
		.out_valid (out_valid),
		.out_item  (out_item),
		.out_stall (out_stall)
	);

	// input backpressure comes only from a stalled, full output
	`HCI_ASSERT_NOW(a_stall_source, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without output stall")

	// a flagged configuration carries a zero index
	`HCI_ASSERT_NOW(a_error_zero, clk, arst_n, out_valid && out_item.config_error, out_item.hilbert_index == '0, "config error with nonzero index")

	// a good index never reaches past dims times bits
	`HCI_ASSERT_NOW(a_index_span, clk, arst_n, out_valid && !out_item.config_error, (out_item.hilbert_index >> idx_span) == '0, "index wider than dims times bits")

endmodule

>>> design/hci_level.sv
// one bit level of the inverse undo pass, one register stage
// depends on hci_pkg
module hci_level (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hci_pkg::cfg_t              cfg,
	input  logic [hci_pkg::LVL_W-1:0]  level,
	input  hci_pkg::stage_t            up,
	output logic                       up_ready,
	output hci_pkg::stage_t            dn,
	input  logic                       dn_ready
);

	hci_pkg::axes_t x_nxt;
	hci_pkg::word_t low_mask;
	hci_pkg::word_t t;
	logic           active;
	logic           valid_s1;
	hci_pkg::axes_t x_s1;

	// inversions and exchanges below this level, axis by axis
	always_comb begin
		x_nxt    = up.x;
		low_mask = (hci_pkg::word_t'(1) << level) - hci_pkg::word_t'(1);
		active   = (cfg.dims > hci_pkg::dims_t'(1)) && (hci_pkg::bits_t'(level) < cfg.bits);
		t        = '0;
		for (int i = 0; i < hci_pkg::MAX_DIMS; i++) begin
			if (active && (hci_pkg::dims_t'(i) < cfg.dims)) begin
				if (x_nxt[i][level]) begin
					x_nxt[0] = x_nxt[0] ^ low_mask;
				end else begin
					t        = (x_nxt[0] ^ x_nxt[i]) & low_mask;
					x_nxt[0] = x_nxt[0] ^ t;
					x_nxt[i] = x_nxt[i] ^ t;
				end
			end
		end
	end

	// stage moves when empty or when the next one takes its item
	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up.valid) begin
			x_s1 <= x_nxt;
		end
	end

	assign dn.valid = valid_s1;
	assign dn.x     = x_s1;

endmodule

>>> design/hci_gray.sv
// gray encode across the axes, one register stage
// depends on hci_pkg
module hci_gray (
	input  logic            clk,
	input  logic            arst_n,
	input  hci_pkg::cfg_t   cfg,
	input  hci_pkg::stage_t up,
	output logic            up_ready,
	output hci_pkg::stage_t dn,
	input  logic            dn_ready
);

	hci_pkg::axes_t x_nxt;
	hci_pkg::word_t last;
	hci_pkg::word_t t;
	logic           valid_s1;
	hci_pkg::axes_t x_s1;

	// prefix xor over the axes, then the suffix parity of the last axis
	always_comb begin
		x_nxt = up.x;
		last  = '0;
		t     = '0;
		if (cfg.dims > hci_pkg::dims_t'(1)) begin
			for (int i = 1; i < hci_pkg::MAX_DIMS; i++) begin
				if (hci_pkg::dims_t'(i) < cfg.dims) begin
					x_nxt[i] = x_nxt[i] ^ x_nxt[i-1];
				end
			end
			for (int i = 0; i < hci_pkg::MAX_DIMS; i++) begin
				if (hci_pkg::dims_t'(i) == cfg.dims - hci_pkg::dims_t'(1)) begin
					last = x_nxt[i];
				end
			end
			for (int j = 0; j < hci_pkg::MAX_BITS - 1; j++) begin
				t[j] = ^(last >> (j + 1));
			end
			for (int i = 0; i < hci_pkg::MAX_DIMS; i++) begin
				x_nxt[i] = x_nxt[i] ^ t;
			end
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up.valid) begin
			x_s1 <= x_nxt;
		end
	end

	assign dn.valid = valid_s1;
	assign dn.x     = x_s1;

endmodule

>>> design/hci_pack.sv
// bit interleave, configuration check and output register
// depends on hci_pkg
module hci_pack (
	input  logic               clk,
	input  logic               arst_n,
	input  hci_pkg::cfg_t      cfg,
	input  hci_pkg::stage_t    up,
	output logic               up_ready,
	output logic               out_valid,
	output hci_pkg::out_item_t out_item,
	input  logic               out_stall
);

	logic [hci_pkg::IDX_W-1:0] idx;
	hci_pkg::prod_t            span;
	logic                      bad;
	hci_pkg::out_item_t        item_nxt;
	logic                      valid_s1;
	hci_pkg::out_item_t        item_s1;

	// fixed wiring per axis count, picked by dims
	always_comb begin
		int pos;
		idx = '0;
		pos = 0;
		for (int nn = 1; nn <= hci_pkg::MAX_DIMS; nn++) begin
			if (cfg.dims == hci_pkg::dims_t'(nn)) begin
				for (int lvl = 0; lvl < hci_pkg::MAX_BITS; lvl++) begin
					for (int i = 0; i < nn; i++) begin
						pos = lvl * nn + nn - 1 - i;
						if (pos < hci_pkg::IDX_W) begin
							idx[hci_pkg::IDX_IW'(pos)] = up.x[i][lvl];
						end
					end
				end
			end
		end
	end

	// configuration check
	always_comb begin
		span = hci_pkg::prod_t'(cfg.dims) * hci_pkg::prod_t'(cfg.bits);
		bad  = (cfg.dims == '0) || (cfg.dims > hci_pkg::dims_t'(hci_pkg::MAX_DIMS))
			|| (cfg.bits == '0) || (cfg.bits > hci_pkg::bits_t'(hci_pkg::MAX_BITS))
			|| (span > hci_pkg::prod_t'(hci_pkg::IDX_W));
		item_nxt.hilbert_index = bad ? '0 : idx;
		item_nxt.config_error  = bad;
	end

	assign up_ready = !valid_s1 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up.valid) begin
			item_s1 <= item_nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule
